// ===== src/ospa_pkg.sv =====
package ospa_pkg;

  // Default pool size and the fixed field widths of the request and result.
  localparam int OSPA_POOL_SIZE = 32;
  localparam int SLOT_NUM_W     = 5;
  localparam int STATUS_W       = 2;

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    FSM_IDLE   = 2'd0,
    FSM_SEARCH = 2'd1,
    FSM_APPLY  = 2'd2
  } fsm_t;

  // Command broadcast to every cell of the row.
  typedef enum logic [2:0] {
    CMD_HOLD    = 3'd0,
    CMD_ALLOC   = 3'd1,
    CMD_LATCH   = 3'd2,
    CMD_SHIFT   = 3'd3,
    CMD_RELEASE = 3'd4
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t             cmd;
    logic [SLOT_NUM_W-1:0] want;
  } cell_ctrl_t;

endpackage

// ===== src/ospa_req_if.sv =====
interface ospa_req_if;
  import ospa_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  op;
  logic [SLOT_NUM_W-1:0] slot_number;

  modport source (output valid, output op, output slot_number, input ready);
  modport sink   (input valid, input op, input slot_number, output ready);

endinterface

// ===== src/ospa_rsp_if.sv =====
interface ospa_rsp_if;
  import ospa_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [SLOT_NUM_W-1:0] granted_slot;
  logic [STATUS_W-1:0]   status;

  modport source (output valid, output granted_slot, output status, input ready);
  modport sink   (input valid, input granted_slot, input status, output ready);

endinterface

// ===== src/ospa_cell.sv =====
module ospa_cell #(
  parameter int POOL_SIZE = ospa_pkg::OSPA_POOL_SIZE,
  parameter int INDEX     = 0,
  parameter int IDX_W     = $clog2(POOL_SIZE)
) (
  input  logic                clk,
  input  logic                rst,
  input  ospa_pkg::cell_ctrl_t ctrl,
  input  logic [IDX_W-1:0]    head_slot,
  input  logic [IDX_W-1:0]    up_slot,
  input  logic                up_free,
  input  logic                up_below,
  input  logic [IDX_W-1:0]    dn_slot,
  input  logic                dn_free,
  output logic [IDX_W-1:0]    slot,
  output logic                free,
  output logic                below
);
  import ospa_pkg::*;

  localparam int CMP_W = (IDX_W > SLOT_NUM_W) ? IDX_W : SLOT_NUM_W;

  logic [IDX_W-1:0] slot_next;
  logic             free_next;
  logic             below_next;
  logic [CMP_W-1:0] slot_ext;
  logic [CMP_W-1:0] want_ext;

  assign slot_ext = CMP_W'(slot);
  assign want_ext = CMP_W'(ctrl.want);

  always_comb begin
    slot_next  = slot;
    free_next  = free;
    below_next = below;
    unique case (ctrl.cmd)
      CMD_ALLOC: begin
        // The free part slides down by one; its top takes the old head.
        if (free) begin
          slot_next = up_free ? up_slot : head_slot;
          free_next = up_free;
        end
      end
      CMD_LATCH: begin
        below_next = !free && (slot_ext == want_ext);
      end
      CMD_SHIFT: begin
        below_next = below | up_below;
      end
      CMD_RELEASE: begin
        // Cells from the free boundary up to the hit slide up by one; the
        // boundary cell takes the released slot as the new free tail.
        if (below && !free) begin
          slot_next = dn_free ? want_ext[IDX_W-1:0] : dn_slot;
        end
        free_next  = free | dn_free;
        below_next = 1'b0;
      end
      CMD_HOLD: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot  <= IDX_W'(INDEX);
      free  <= 1'b1;
      below <= 1'b0;
    end else begin
      slot  <= slot_next;
      free  <= free_next;
      below <= below_next;
    end
  end

endmodule

// ===== src/ordered_slot_pool_allocator.sv =====
// Ordered slot pool allocator. The pool of POOL_SIZE slots lives in a row of
// cells, one slot number per cell. The low cells hold the free list in order,
// head in cell 0, and the cells above them hold the active list in reverse
// order, tail next to the free part. After reset every slot is free, in order
// 0 to POOL_SIZE-1. An allocate request is done in the cycle it is taken: the
// free head is granted and the free part slides down one cell, so the head
// becomes the new active tail. A release has a latch step in which every
// active cell compares its slot with the named one, a search in which the hit
// mark ripples one cell per cycle toward cell 0, and an apply step in which
// the cells between the free boundary and the hit slide up so that the
// released slot lands as the free tail; apply waits while the output
// register is full. The result is written into an output register on the
// last edge of the request and is offered from the next cycle, and a new
// request is taken in the same cycle in which the previous result is taken.
// A pool with nothing free answers an allocate with status empty; a
// release of a slot that is not active answers status not found and changes
// nothing. granted_slot is zero on every result that is not a successful
// allocation and carries the low five bits of the slot number.
module ordered_slot_pool_allocator #(
  parameter int POOL_SIZE = ospa_pkg::OSPA_POOL_SIZE
) (
  input logic        clk,
  input logic        rst,
  ospa_req_if.sink   req,
  ospa_rsp_if.source rsp
);
  import ospa_pkg::*;

  localparam int IDX_W = $clog2(POOL_SIZE);
  localparam int CMP_W = (IDX_W > SLOT_NUM_W) ? IDX_W : SLOT_NUM_W;
  localparam int CNT_W = $clog2(POOL_SIZE);

  fsm_t                  state;
  fsm_t                  state_next;
  logic [CNT_W-1:0]      cnt;
  logic [CNT_W-1:0]      cnt_next;
  logic [SLOT_NUM_W-1:0] want;
  logic [SLOT_NUM_W-1:0] want_next;

  logic                  out_valid;
  logic                  out_valid_next;
  logic [SLOT_NUM_W-1:0] out_granted;
  logic [SLOT_NUM_W-1:0] out_granted_next;
  status_t               out_status;
  status_t               out_status_next;

  cell_ctrl_t            ctrl;
  logic                  accept;
  logic                  out_free;
  logic [CMP_W-1:0]      head_ext;

  logic [IDX_W-1:0]      slot_arr [POOL_SIZE];
  logic [POOL_SIZE-1:0]  free_vec;
  logic [POOL_SIZE-1:0]  below_vec;

  // The output register is free when it is empty or being emptied now.
  assign out_free  = !out_valid || rsp.ready;
  assign req.ready = (state == FSM_IDLE) && out_free;
  assign accept    = req.valid && req.ready;
  assign head_ext  = CMP_W'(slot_arr[0]);

  assign rsp.valid        = out_valid;
  assign rsp.granted_slot = out_granted;
  assign rsp.status       = out_status;

  // Row of cells. Cell 0 sees an always-free cell below it, and the top
  // cell sees an active cell with no mark above it.
  for (genvar i = 0; i < POOL_SIZE; i++) begin : g_cell
    logic [IDX_W-1:0] up_slot;
    logic             up_free;
    logic             up_below;
    logic [IDX_W-1:0] dn_slot;
    logic             dn_free;

    if (i == POOL_SIZE - 1) begin : g_top
      assign up_slot  = '0;
      assign up_free  = 1'b0;
      assign up_below = 1'b0;
    end else begin : g_mid_up
      assign up_slot  = slot_arr[i+1];
      assign up_free  = free_vec[i+1];
      assign up_below = below_vec[i+1];
    end

    if (i == 0) begin : g_bottom
      assign dn_slot = '0;
      assign dn_free = 1'b1;
    end else begin : g_mid_dn
      assign dn_slot = slot_arr[i-1];
      assign dn_free = free_vec[i-1];
    end

    ospa_cell #(
      .POOL_SIZE (POOL_SIZE),
      .INDEX     (i),
      .IDX_W     (IDX_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .head_slot (slot_arr[0]),
      .up_slot   (up_slot),
      .up_free   (up_free),
      .up_below  (up_below),
      .dn_slot   (dn_slot),
      .dn_free   (dn_free),
      .slot      (slot_arr[i]),
      .free      (free_vec[i]),
      .below     (below_vec[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FSM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    cnt_next         = cnt;
    want_next        = want;
    out_valid_next   = out_valid && !rsp.ready;
    out_granted_next = out_granted;
    out_status_next  = out_status;
    ctrl.cmd         = CMD_HOLD;
    ctrl.want        = want;
    unique case (state)
      FSM_IDLE: begin
        if (accept) begin
          out_granted_next = '0;
          if (req.op == OP_ALLOC) begin
            out_valid_next = 1'b1;
            if (free_vec[0]) begin
              ctrl.cmd         = CMD_ALLOC;
              out_granted_next = head_ext[SLOT_NUM_W-1:0];
              out_status_next  = ST_OK;
            end else begin
              out_status_next = ST_EMPTY;
            end
          end else begin
            ctrl.cmd   = CMD_LATCH;
            ctrl.want  = req.slot_number;
            want_next  = req.slot_number;
            cnt_next   = '0;
            state_next = FSM_SEARCH;
          end
        end
      end
      FSM_SEARCH: begin
        ctrl.cmd = CMD_SHIFT;
        if (cnt == CNT_W'(POOL_SIZE - 2)) begin
          state_next = FSM_APPLY;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      FSM_APPLY: begin
        // Cell 0 now holds the OR of all hit marks.
        if (out_free) begin
          ctrl.cmd         = below_vec[0] ? CMD_RELEASE : CMD_HOLD;
          out_valid_next   = 1'b1;
          out_granted_next = '0;
          out_status_next  = below_vec[0] ? ST_OK : ST_NOT_FOUND;
          state_next       = FSM_IDLE;
        end
      end
      default: begin
        state_next = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
    cnt         <= cnt_next;
    want        <= want_next;
    out_granted <= out_granted_next;
    out_status  <= out_status_next;
  end

  // The free cells always form a contiguous run starting at cell 0.
  logic [POOL_SIZE:0] free_ext;
  assign free_ext = {1'b0, free_vec};

  a_free_thermometer: assert property (@(posedge clk) disable iff (rst)
    (free_ext & (free_ext + (POOL_SIZE+1)'(1))) == '0)
    else $error("free cells are not contiguous from cell 0");

  // Slot numbers are unique, so at most one cell can match a release.
  a_single_hit: assert property (@(posedge clk) disable iff (rst)
    (state == FSM_SEARCH && cnt == '0) |-> $onehot0(below_vec))
    else $error("more than one cell matched the released slot");

  a_alloc_result: assert property (@(posedge clk) disable iff (rst)
    (accept && req.op == OP_ALLOC) |=> out_valid)
    else $error("allocate request produced no result");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (accept && req.op == OP_ALLOC && !free_vec[0]) |=>
      (out_status == ST_EMPTY && out_granted == '0))
    else $error("allocate on an empty pool did not report empty");

  a_release_idle: assert property (@(posedge clk) disable iff (rst)
    (state == FSM_APPLY && out_free) |=> (state == FSM_IDLE && out_valid))
    else $error("release did not finish after its apply cycle");

endmodule
